// ----- rtl/mhkt_pkg.sv -----
`timescale 1ns / 1ps

package mhkt_pkg;

	// Killer slot count; history geometry is fixed by the board.
	localparam int PLY_SLOTS    = 128;
	localparam int KILL_AW      = (PLY_SLOTS > 1) ? $clog2(PLY_SLOTS) : 1;
	localparam int SQUARES      = 64;
	localparam int HIST_ENTRIES = 2 * SQUARES * SQUARES;
	localparam int HIST_AW      = $clog2(HIST_ENTRIES);

	// Action codes
	localparam logic [2:0] ACT_QUERY    = 3'd0;
	localparam logic [2:0] ACT_REWARD   = 3'd1;
	localparam logic [2:0] ACT_PENALIZE = 3'd2;
	localparam logic [2:0] ACT_AGE      = 3'd3;
	localparam logic [2:0] ACT_CLEAR    = 3'd4;

	// Score source codes
	localparam logic [1:0] SRC_HISTORY = 2'd0;
	localparam logic [1:0] SRC_FIRST   = 2'd1;
	localparam logic [1:0] SRC_SECOND  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_HISTORY_LIMIT = 2'd0;
	localparam logic [1:0] CFG_FIRST_SCORE   = 2'd1;
	localparam logic [1:0] CFG_SECOND_SCORE  = 2'd2;

	localparam int CFG_DW = 31;

	typedef struct packed {
		logic [2:0]  action;
		logic        side;
		logic [5:0]  from_square;
		logic [5:0]  to_square;
		logic [15:0] move_code;
		logic [6:0]  depth;
		logic [7:0]  ply;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] score;
		logic [1:0]         source;
	} result_t;

endpackage

// ----- rtl/move_history_killer_table.sv -----
`timescale 1ns / 1ps

// Move-ordering store: signed history score per (side, from, to) plus two
// killer moves per ply.
// Command channel: a beat is taken on a clock edge with start high and busy
// low. Every beat yields exactly one result beat: done is high for one
// cycle with result valid; there is no back-pressure, the receiver must
// take it then.
// Query, reward, penalize and unused actions: one read-modify-write of a
// history entry and the killer pair of the ply. The accepting edge
// registers the command and the synchronous memory reads; the execute
// state then computes, writes back and registers done. A new beat may be
// taken in the cycle done is shown.
// Age walks all 8192 history entries with a read and a write per cycle.
// Clear sweeps the history and killer memories with one write per cycle.
// Reset: the same clearing sweep runs; busy stays high and no result beat
// comes out of it. Configuration writes are taken anytime.
module move_history_killer_table (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  mhkt_pkg::cmd_t          cmd,
	output logic                    done,
	output mhkt_pkg::result_t       result,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [mhkt_pkg::CFG_DW-1:0] cfg_data
);
	import mhkt_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_AGE
	} state_t;

	state_t              state_q;
	logic [HIST_AW:0]    cnt_q;       // sweep counter, top bit marks end of age reads
	logic                report_q;    // sweep was a clear command, not reset
	logic                done_q;
	result_t             result_q;
	cmd_t                cmd_s1;
	logic [13:0]         dsq_s1;
	logic                age_v_s1;
	logic [HIST_AW-1:0]  age_addr_s1;

	// configuration
	logic [29:0] limit_q;
	logic [30:0] first_score_q;
	logic [30:0] second_score_q;

	// memories
	logic signed [31:0]  hist_mem [HIST_ENTRIES];
	logic [31:0]         kill_mem [PLY_SLOTS];   // {first, second}
	logic signed [31:0]  hist_rdata_s1;
	logic [31:0]         kill_rdata_s1;
	logic [HIST_AW-1:0]  hist_raddr;
	logic [HIST_AW-1:0]  hist_waddr;
	logic signed [31:0]  hist_wdata;
	logic                hist_we;
	logic [KILL_AW-1:0]  kill_waddr;
	logic [31:0]         kill_wdata;
	logic                kill_we;

	// datapath
	logic                accept;
	logic [HIST_AW-1:0]  idx_s1;
	logic                ply_ok;
	logic [15:0]         first_k;
	logic [15:0]         second_k;
	logic                first_hit;
	logic                second_hit;
	logic                is_reward;
	logic                is_pen;
	logic signed [33:0]  dsq34;
	logic signed [33:0]  delta;
	logic signed [33:0]  sum;
	logic signed [33:0]  lim34;
	logic signed [31:0]  hist_new;
	logic signed [31:0]  age_half;
	result_t             exec_res;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q        <= 30'd16384;
			first_score_q  <= 31'd900000;
			second_score_q <= 31'd800000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HISTORY_LIMIT: limit_q        <= cfg_data[29:0];
				CFG_FIRST_SCORE:   first_score_q  <= cfg_data;
				CFG_SECOND_SCORE:  second_score_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Read ports: address from the command in idle, from the walk counter in age.
	assign hist_raddr = (state_q == S_AGE) ? cnt_q[HIST_AW-1:0]
	                                       : {cmd.side, cmd.from_square, cmd.to_square};

	always_ff @(posedge clk) begin
		hist_rdata_s1 <= hist_mem[hist_raddr];
		if (hist_we)
			hist_mem[hist_waddr] <= hist_wdata;
	end

	always_ff @(posedge clk) begin
		kill_rdata_s1 <= kill_mem[cmd.ply[KILL_AW-1:0]];
		if (kill_we)
			kill_mem[kill_waddr] <= kill_wdata;
	end

	// Execute stage: killer compare and saturating history update.
	assign idx_s1     = {cmd_s1.side, cmd_s1.from_square, cmd_s1.to_square};
	assign ply_ok     = {1'b0, cmd_s1.ply} < 9'(PLY_SLOTS);
	assign first_k    = kill_rdata_s1[31:16];
	assign second_k   = kill_rdata_s1[15:0];
	assign first_hit  = ply_ok && (first_k != 16'd0) && (first_k == cmd_s1.move_code);
	assign second_hit = ply_ok && (second_k != 16'd0) && (second_k == cmd_s1.move_code);
	assign is_reward  = (cmd_s1.action == ACT_REWARD);
	assign is_pen     = (cmd_s1.action == ACT_PENALIZE);

	assign dsq34 = $signed({20'd0, dsq_s1});
	assign delta = is_pen ? (34'sd0 - dsq34) : dsq34;
	assign sum   = $signed({{2{hist_rdata_s1[31]}}, hist_rdata_s1}) + delta;
	assign lim34 = $signed({4'd0, limit_q});

	always_comb begin
		if (sum > lim34)
			hist_new = lim34[31:0];
		else if (sum < -lim34)
			hist_new = 32'sd0 - $signed({2'd0, limit_q});
		else
			hist_new = sum[31:0];
	end

	// halve toward zero
	assign age_half = (hist_rdata_s1 + $signed({31'd0, hist_rdata_s1[31]})) >>> 1;

	always_comb begin
		exec_res.score  = 32'sd0;
		exec_res.source = SRC_HISTORY;
		if (cmd_s1.action == ACT_QUERY) begin
			if (first_hit) begin
				exec_res.score  = $signed({1'b0, first_score_q});
				exec_res.source = SRC_FIRST;
			end else if (second_hit) begin
				exec_res.score  = $signed({1'b0, second_score_q});
				exec_res.source = SRC_SECOND;
			end else begin
				exec_res.score  = hist_rdata_s1;
			end
		end
	end

	// Write ports
	always_comb begin
		hist_we    = 1'b0;
		hist_waddr = idx_s1;
		hist_wdata = hist_new;
		kill_we    = 1'b0;
		kill_waddr = cmd_s1.ply[KILL_AW-1:0];
		kill_wdata = {cmd_s1.move_code, first_k};
		case (state_q)
			S_CLEAR: begin
				hist_we    = 1'b1;
				hist_waddr = cnt_q[HIST_AW-1:0];
				hist_wdata = 32'sd0;
				kill_we    = cnt_q < (HIST_AW + 1)'(PLY_SLOTS);
				kill_waddr = cnt_q[KILL_AW-1:0];
				kill_wdata = 32'd0;
			end
			S_EXEC: begin
				hist_we = (is_reward && ply_ok) || is_pen;
				kill_we = is_reward && ply_ok && (first_k != cmd_s1.move_code);
			end
			S_AGE: begin
				hist_we    = age_v_s1;
				hist_waddr = age_addr_s1;
				hist_wdata = age_half;
			end
			default: ;
		endcase
	end

	// Control and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			cnt_q    <= '0;
			report_q <= 1'b0;
			done_q   <= 1'b0;
			age_v_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[HIST_AW-1:0] == {HIST_AW{1'b1}}) begin
						state_q         <= S_IDLE;
						cnt_q           <= '0;
						done_q          <= report_q;
						result_q.score  <= 32'sd0;
						result_q.source <= SRC_HISTORY;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cmd_s1 <= cmd;
						dsq_s1 <= {7'd0, cmd.depth} * {7'd0, cmd.depth};
						cnt_q  <= '0;
						case (cmd.action)
							ACT_AGE: state_q <= S_AGE;
							ACT_CLEAR: begin
								state_q  <= S_CLEAR;
								report_q <= 1'b1;
							end
							default: state_q <= S_EXEC;
						endcase
					end
				end
				S_EXEC: begin
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					result_q <= exec_res;
				end
				S_AGE: begin
					// read runs one entry ahead of the halving write
					age_v_s1    <= !cnt_q[HIST_AW];
					age_addr_s1 <= cnt_q[HIST_AW-1:0];
					if (!cnt_q[HIST_AW])
						cnt_q <= cnt_q + 1'b1;
					if (cnt_q[HIST_AW]) begin
						state_q         <= S_IDLE;
						cnt_q           <= '0;
						age_v_s1        <= 1'b0;
						done_q          <= 1'b1;
						result_q.score  <= 32'sd0;
						result_q.source <= SRC_HISTORY;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/mhkt_checker.sv -----
`timescale 1ns / 1ps

module mhkt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input mhkt_pkg::result_t result
);
	import mhkt_pkg::*;

	// a taken beat always occupies the block next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	// result beats only come out of work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without prior work");

	// block is free again when a result is shown
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while result beat shown");

	// result beats never come back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result beats");

	a_source_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.source == SRC_HISTORY || result.source == SRC_FIRST
		          || result.source == SRC_SECOND))
		else $error("undefined score source");

endmodule

bind move_history_killer_table mhkt_checker u_mhkt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ----- tb/move_history_killer_table_tb.sv -----
`timescale 1ns / 1ps

module move_history_killer_table_tb;
	import mhkt_pkg::*;

	// Actions the block takes but ignores
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
	// Register index with no register behind it
	localparam logic [1:0] CFG_SPARE = 2'd3;

	localparam logic [30:0] SCORE_MAX = 31'h7FFF_FFFF;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         start;
	logic         busy;
	cmd_t         cmd;
	logic         done;
	result_t      result;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	move_history_killer_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop; the slowest legal run is about 4 ms (reset sweep, at most
	// 16 age/clear whole-table sweeps, ~625 beats with capped gaps).
	initial begin
		#15_000_000;
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the table and its registers
	// ------------------------------------------------------------------
	int           hist_score [HIST_ENTRIES];
	logic [15:0]  first_killer [PLY_SLOTS];
	logic [15:0]  second_killer [PLY_SLOTS];
	logic [29:0]  hist_limit;
	logic [30:0]  first_score;
	logic [30:0]  second_score;

	result_t      expected_scores [$];

	int n_bad;
	int n_cmds;
	int n_results;
	int n_sweeps;
	int n_killer_hits;
	int sweeps_left;

	function automatic void clear_tables();
		for (int i = 0; i < HIST_ENTRIES; i++)
			hist_score[i] = 0;
		for (int i = 0; i < PLY_SLOTS; i++) begin
			first_killer[i]  = '0;
			second_killer[i] = '0;
		end
	endfunction

	// Add delta to one history entry, clamped to +/- hist_limit
	function automatic void bump_history(input logic [HIST_AW-1:0] idx, input longint delta);
		longint v;
		longint lim;
		lim = longint'(hist_limit);
		v = longint'(hist_score[idx]) + delta;
		if (v > lim)
			v = lim;
		else if (v < -lim)
			v = -lim;
		hist_score[idx] = int'(v);
	endfunction

	// Ordering score of one command; updates the shadow table as the block does
	function automatic result_t score_move(input cmd_t c);
		result_t           r;
		logic [HIST_AW-1:0] idx;
		longint            sq;
		bit                ply_ok;
		r = '0;
		idx = {c.side, c.from_square, c.to_square};
		sq = longint'(c.depth) * longint'(c.depth);
		ply_ok = c.ply < PLY_SLOTS;
		case (c.action)
		ACT_QUERY: begin
			// zero is the no-move marker and never matches
			if (ply_ok && first_killer[c.ply] != '0 && first_killer[c.ply] == c.move_code) begin
				r.score  = {1'b0, first_score};
				r.source = SRC_FIRST;
			end else if (ply_ok && second_killer[c.ply] != '0
					&& second_killer[c.ply] == c.move_code) begin
				r.score  = {1'b0, second_score};
				r.source = SRC_SECOND;
			end else begin
				r.score  = hist_score[idx];
				r.source = SRC_HISTORY;
			end
			if (r.source != SRC_HISTORY)
				n_killer_hits++;
		end
		ACT_REWARD: begin
			// ply past the slots: no killer push, no bonus
			if (ply_ok) begin
				if (first_killer[c.ply] != c.move_code) begin
					second_killer[c.ply] = first_killer[c.ply];
					first_killer[c.ply]  = c.move_code;
				end
				bump_history(idx, sq);
			end
		end
		ACT_PENALIZE: begin
			bump_history(idx, -sq);
		end
		ACT_AGE: begin
			// signed divide truncates toward zero
			for (int i = 0; i < HIST_ENTRIES; i++)
				hist_score[i] = hist_score[i] / 2;
			n_sweeps++;
		end
		ACT_CLEAR: begin
			clear_tables();
			n_sweeps++;
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checker: done is a one-cycle strobe, no back-pressure
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t w;
		if (arst_n === 1'b1 && done === 1'b1) begin
			n_results++;
			if (expected_scores.size() == 0) begin
				$error("result beat with nothing outstanding: score %0d source %0d",
					result.score, result.source);
				n_bad++;
			end else begin
				w = expected_scores.pop_front();
				if (result.score !== w.score) begin
					$error("score: expected %0d, got %0d", w.score, result.score);
					n_bad++;
				end
				if (result.source !== w.source) begin
					$error("source: expected %0d, got %0d", w.source, result.source);
					n_bad++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Present one command beat, wait for it to be taken, record what the
	// block must answer. Where a directed row gives a value, it wins over
	// the shadow model; the model still runs to keep its state in step.
	// Afterwards idle the sender with probability idle_pct per cycle.
	task automatic issue(input cmd_t c, input bit has_want, input result_t want,
			input int idle_pct);
		result_t r;
		int      gap;
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		r = score_move(c);
		expected_scores.push_back(has_want ? want : r);
		n_cmds++;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			gap = 0;
			do begin
				@(posedge clk);
				gap++;
			end while (gap < 60 && $urandom_range(0, 99) < idle_pct);
		end
	endtask

	// Every command yields one result, so an empty queue means idle
	task automatic settle();
		while (expected_scores.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
		CFG_HISTORY_LIMIT: hist_limit   = val[29:0];
		CFG_FIRST_SCORE:   first_score  = val;
		CFG_SECOND_SCORE:  second_score = val;
		default: begin
		end
		endcase
	endtask

	task automatic program_regs(input logic [30:0] lim, input logic [30:0] s1,
			input logic [30:0] s2, input bit poke_spare);
		write_reg(CFG_HISTORY_LIMIT, lim);
		write_reg(CFG_FIRST_SCORE, s1);
		write_reg(CFG_SECOND_SCORE, s2);
		if (poke_spare)
			write_reg(CFG_SPARE, 31'($urandom()));
		cfg_we <= 1'b0;
	endtask

	// Random traffic. Most beats stay on a few squares, plies and moves so
	// that rewards land in killer slots the later queries then hit, and
	// history entries build up to the limit; the rest is spread over the
	// whole field ranges.
	task automatic run_phase(input int n_items, input int idle_pct);
		cmd_t c;
		int   r;
		for (int k = 0; k < n_items; k++) begin
			r = $urandom_range(0, 99);
			if (r < 2 && sweeps_left > 0) begin
				c.action = $urandom_range(0, 1) ? ACT_AGE : ACT_CLEAR;
				sweeps_left--;
			end else if (r < 6)
				c.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
			else if (r < 46)
				c.action = ACT_QUERY;
			else if (r < 76)
				c.action = ACT_REWARD;
			else
				c.action = ACT_PENALIZE;

			c.side = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 99) < 60) begin
				c.from_square = 6'($urandom_range(0, 3));
				c.to_square   = 6'($urandom_range(0, 3));
			end else begin
				c.from_square = 6'($urandom());
				c.to_square   = 6'($urandom());
			end

			// pool of 16 moves, the no-move marker among them
			if ($urandom_range(0, 99) < 75)
				c.move_code = ($urandom_range(0, 1) ? 16'hFFF8 : 16'h0000)
					| 16'($urandom_range(0, 7));
			else
				c.move_code = 16'($urandom());

			r = $urandom_range(0, 99);
			if (r < 10)
				c.depth = '0;
			else if (r < 20)
				c.depth = 7'd127;
			else
				c.depth = 7'($urandom());

			// mostly low plies; the last slot and the first one past it often
			r = $urandom_range(0, 99);
			if (r < 60)
				c.ply = 8'($urandom_range(0, 3));
			else if (r < 75)
				c.ply = $urandom_range(0, 1) ? 8'(PLY_SLOTS - 1) : 8'(PLY_SLOTS);
			else
				c.ply = 8'($urandom());

			issue(c, 1'b0, '0, idle_pct);
		end
	endtask

	// ------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------
	typedef struct {
		cmd_t    c;
		bit      has_want;
		result_t want;
	} dir_row_t;

	dir_row_t rows [$];

	task automatic add_row(input logic [2:0] act, input logic sd, input logic [5:0] fr,
			input logic [5:0] to, input logic [15:0] mv, input logic [6:0] dp,
			input logic [7:0] pl, input bit has_want, input int sc, input logic [1:0] src);
		dir_row_t d;
		d.c.action      = act;
		d.c.side        = sd;
		d.c.from_square = fr;
		d.c.to_square   = to;
		d.c.move_code   = mv;
		d.c.depth       = dp;
		d.c.ply         = pl;
		d.has_want      = has_want;
		d.want.score    = sc;
		d.want.source   = src;
		rows.push_back(d);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_HISTORY_LIMIT;
		cfg_data  = '0;
		n_bad = 0;
		n_cmds = 0;
		n_results = 0;
		n_sweeps = 0;
		n_killer_hits = 0;
		sweeps_left = 14;
		hist_limit   = 30'd16384;
		first_score  = 31'd900000;
		second_score = 31'd800000;
		clear_tables();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at reset register values (limit 16384, killer
		// scores 900000 / 800000). The first beat waits out the clearing
		// sweep that follows reset.
		// fresh table; zero move never matches the empty killer marker
		add_row(ACT_QUERY, 1'b0, 6'd0, 6'd0, 16'h0000, 7'd0, 8'd0, 1, 0, SRC_HISTORY);
		add_row(ACT_QUERY, 1'b1, 6'd63, 6'd63, 16'hFFFF, 7'd127, 8'd255, 1, 0, SRC_HISTORY);
		// killer push and shift on ply 0
		add_row(ACT_REWARD, 1'b0, 6'd0, 6'd0, 16'h0101, 7'd127, 8'd0, 1, 0, SRC_HISTORY);
		add_row(ACT_QUERY, 1'b0, 6'd9, 6'd9, 16'h0101, 7'd0, 8'd0, 1, 900000, SRC_FIRST);
		add_row(ACT_REWARD, 1'b0, 6'd1, 6'd2, 16'h0202, 7'd3, 8'd0, 1, 0, SRC_HISTORY);
		add_row(ACT_QUERY, 1'b0, 6'd9, 6'd9, 16'h0101, 7'd0, 8'd0, 1, 800000, SRC_SECOND);
		add_row(ACT_QUERY, 1'b0, 6'd9, 6'd9, 16'h0202, 7'd0, 8'd0, 1, 900000, SRC_FIRST);
		// same move again: pair stays, history still grows
		add_row(ACT_REWARD, 1'b0, 6'd1, 6'd2, 16'h0202, 7'd5, 8'd0, 0, 0, SRC_HISTORY);
		add_row(ACT_QUERY, 1'b0, 6'd9, 6'd9, 16'h0101, 7'd0, 8'd0, 1, 800000, SRC_SECOND);
		add_row(ACT_QUERY, 1'b0, 6'd0, 6'd0, 16'h7777, 7'd0, 8'd0, 1, 16129, SRC_HISTORY);
		// ply past the slots: reward is a no-op, query skips killers
		add_row(ACT_REWARD, 1'b0, 6'd0, 6'd0, 16'h7777, 7'd127, 8'd200, 1, 0, SRC_HISTORY);
		add_row(ACT_QUERY, 1'b0, 6'd0, 6'd0, 16'h7777, 7'd0, 8'd0, 1, 16129, SRC_HISTORY);
		add_row(ACT_QUERY, 1'b0, 6'd1, 6'd2, 16'h0202, 7'd0, 8'd128, 0, 0, SRC_HISTORY);
		// last slot; bonus saturates at the limit
		add_row(ACT_REWARD, 1'b0, 6'd0, 6'd0, 16'h0303, 7'd127, 8'd127, 1, 0, SRC_HISTORY);
		add_row(ACT_QUERY, 1'b0, 6'd0, 6'd0, 16'h0303, 7'd0, 8'd127, 1, 900000, SRC_FIRST);
		add_row(ACT_QUERY, 1'b0, 6'd0, 6'd0, 16'h9999, 7'd0, 8'd127, 1, 16384, SRC_HISTORY);
		// penalty applies at any ply, saturates at minus the limit
		add_row(ACT_PENALIZE, 1'b1, 6'd63, 6'd63, 16'hFFFF, 7'd127, 8'd255, 1, 0, SRC_HISTORY);
		add_row(ACT_PENALIZE, 1'b1, 6'd63, 6'd63, 16'hFFFF, 7'd127, 8'd255, 1, 0, SRC_HISTORY);
		add_row(ACT_QUERY, 1'b1, 6'd63, 6'd63, 16'h0000, 7'd0, 8'd255, 1, -16384, SRC_HISTORY);
		add_row(ACT_PENALIZE, 1'b0, 6'd5, 6'd5, 16'h0000, 7'd3, 8'd0, 1, 0, SRC_HISTORY);
		// age: halves, odd negatives truncate toward zero
		add_row(ACT_AGE, 1'b0, 6'd0, 6'd0, 16'h0000, 7'd0, 8'd0, 1, 0, SRC_HISTORY);
		add_row(ACT_QUERY, 1'b1, 6'd63, 6'd63, 16'h0000, 7'd0, 8'd255, 1, -8192, SRC_HISTORY);
		add_row(ACT_QUERY, 1'b0, 6'd5, 6'd5, 16'h0000, 7'd0, 8'd0, 0, 0, SRC_HISTORY);
		// unused action with every field at its top
		add_row(ACT_SPARE_LAST, 1'b1, 6'd63, 6'd63, 16'hFFFF, 7'd127, 8'd255, 1, 0,
			SRC_HISTORY);
		// clear empties killers and history but keeps the registers
		add_row(ACT_CLEAR, 1'b0, 6'd0, 6'd0, 16'h0000, 7'd0, 8'd0, 1, 0, SRC_HISTORY);
		add_row(ACT_QUERY, 1'b0, 6'd0, 6'd0, 16'h0303, 7'd0, 8'd127, 1, 0, SRC_HISTORY);
		add_row(ACT_REWARD, 1'b0, 6'd0, 6'd0, 16'h0404, 7'd0, 8'd3, 1, 0, SRC_HISTORY);
		add_row(ACT_QUERY, 1'b0, 6'd0, 6'd0, 16'h0404, 7'd0, 8'd3, 1, 900000, SRC_FIRST);

		foreach (rows[i])
			issue(rows[i].c, rows[i].has_want, rows[i].want, 0);
		start <= 1'b0;
		settle();

		// Top limit (written with bit 30 set, which the register drops),
		// top first-killer score, zero second; back-to-back beats.
		program_regs(SCORE_MAX, SCORE_MAX, '0, 1'b0);
		run_phase(150, 0);
		start <= 1'b0;
		settle();

		// Limit dropped to one: big entries stay until next touched
		program_regs(31'd1, '0, SCORE_MAX, 1'b0);
		run_phase(150, 87);
		start <= 1'b0;
		settle();

		// Limit zero clamps every update to zero; poke the unused index too
		program_regs('0, 31'($urandom()), 31'($urandom()), 1'b1);
		run_phase(150, 13);
		start <= 1'b0;
		settle();

		// Middling limit, random scores
		program_regs(31'($urandom_range(1, 5000)), 31'($urandom()), 31'($urandom()), 1'b0);
		run_phase(150, 87);
		start <= 1'b0;
		settle();

		// nothing outstanding; make sure no stray beat follows
		repeat (20) @(posedge clk);

		$display("Issued %0d command beats (%0d whole-table sweeps) over five register settings.",
			n_cmds, n_sweeps);
		$display("Checked %0d result beats, %0d of them killer hits.", n_results, n_killer_hits);
		if (n_bad == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- move_history_killer_table.f -----
rtl/mhkt_pkg.sv
rtl/move_history_killer_table.sv
rtl/mhkt_checker.sv
tb/move_history_killer_table_tb.sv
